// File: design/spmr_pkg.sv
package spmr_pkg;

  localparam int WORD_W = 31;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t PM_MODULUS = 31'h7FFF_FFFF;
  localparam logic [14:0] PM_MULT = 15'd16807;

  localparam logic FUNC_DRAW   = 1'b0;
  localparam logic FUNC_RESEED = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_FILL_A = 7'b0000010,
    ST_FILL_B = 7'b0000100,
    ST_DRAW_A = 7'b0001000,
    ST_DRAW_B = 7'b0010000,
    ST_DRAW_C = 7'b0100000,
    ST_DRAW_D = 7'b1000000
  } state_t;

endpackage

// File: design/spmr_req_if.sv
interface spmr_req_if;
  logic               valid;
  logic               ready;
  logic               func;
  spmr_pkg::word_t    seed;

  modport source (output valid, output func, output seed, input ready);
  modport sink (input valid, input func, input seed, output ready);
endinterface

// File: design/spmr_rsp_if.sv
interface spmr_rsp_if;
  logic               valid;
  logic               ready;
  spmr_pkg::word_t    random_value;
  spmr_pkg::word_t    next_state;

  modport source (output valid, output random_value, output next_state, input ready);
  modport sink (input valid, input random_value, input next_state, output ready);
endinterface

// File: design/spmr_lcg.sv
module spmr_lcg (
  input  logic            clk,
  input  spmr_pkg::word_t state,
  output spmr_pkg::word_t state_next
);

  logic [45:0] prod;
  logic [31:0] fold_sum;
  logic [31:0] fold_red;

  // The modulus is a Mersenne number, so the high bits of the product fold back onto the
  // low bits and one conditional subtraction finishes the reduction.
  always_ff @(posedge clk) begin
    prod <= 46'(state) * 46'(spmr_pkg::PM_MULT);
  end

  always_comb begin
    fold_sum = {1'b0, prod[30:0]} + {17'd0, prod[45:31]};
    fold_red = fold_sum - {1'b0, spmr_pkg::PM_MODULUS};
    if (fold_sum >= {1'b0, spmr_pkg::PM_MODULUS}) begin
      state_next = fold_red[30:0];
    end else begin
      state_next = fold_sum[30:0];
    end
  end

endmodule

// File: design/spmr_slot.sv
module spmr_slot #(
  parameter int TABLE_SIZE = 32
) (
  input  logic                          clk,
  input  spmr_pkg::word_t               value,
  output logic [$clog2(TABLE_SIZE)-1:0] slot
);

  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam longint SLOT_DIV = 1 + (longint'(spmr_pkg::PM_MODULUS) - 1) / TABLE_SIZE;
  localparam longint RCP = (longint'(1) << 31) / SLOT_DIV;
  localparam int RCP_W = $clog2(RCP + 1);
  localparam int PROD_W = 31 + RCP_W;
  localparam logic [31:0] DIV_C = 32'(SLOT_DIV);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SIZE - 1);

  logic [PROD_W-1:0] est_prod;
  logic [SLOT_W-1:0] q_est;
  spmr_pkg::word_t   value_d;
  logic [31:0]       back_prod;
  logic [31:0]       remain;

  // The reciprocal estimate is low by at most one; the remainder check corrects it.
  always_comb begin
    est_prod = PROD_W'(value) * PROD_W'(RCP);
  end

  always_ff @(posedge clk) begin
    value_d <= value;
    q_est   <= est_prod[31 +: SLOT_W];
  end

  always_comb begin
    back_prod = 32'(q_est) * DIV_C;
    remain    = {1'b0, value_d} - back_prod;
  end

  always_ff @(posedge clk) begin
    if (remain >= DIV_C && q_est != SLOT_LAST) begin
      slot <= q_est + SLOT_W'(1);
    end else begin
      slot <= q_est;
    end
  end

endmodule

// File: design/spmr_table.sv
module spmr_table #(
  parameter int TABLE_SIZE = 32
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
  input  spmr_pkg::word_t               wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
  output spmr_pkg::word_t               rd_data
);

  spmr_pkg::word_t mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/shuffled_park_miller_random.sv
// A draw request steps through DRAW_A, DRAW_B, DRAW_C and DRAW_D after acceptance; DRAW_D
// holds until the previous response is taken, then loads the response and returns to idle,
// so the block takes no new request until the response is loaded. A reseed, or the first draw
// after reset, first steps the generator WARMUP_STEPS + TABLE_SIZE times through the multiply
// and fold unit, filling the shuffle table. Synchronous reset sets the generator state to one
// and marks the table as empty; the table contents themselves are not cleared.
module shuffled_park_miller_random #(
  parameter int TABLE_SIZE   = 32,
  parameter int WARMUP_STEPS = 8
) (
  input logic          clk,
  input logic          rst,
  spmr_req_if.sink     req,
  spmr_rsp_if.source   rsp
);

  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int STEPS = WARMUP_STEPS + TABLE_SIZE;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);
  localparam logic [CNT_W-1:0] CNT_WARM = CNT_W'(WARMUP_STEPS);

  spmr_pkg::state_t  state;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  fill_pos;
  spmr_pkg::word_t   lcg_state;
  spmr_pkg::word_t   last_output;
  spmr_pkg::word_t   step_next;
  spmr_pkg::word_t   seed_fixed;
  logic [SLOT_W-1:0] slot;
  spmr_pkg::word_t   rd_data;
  logic              rd_en;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  spmr_pkg::word_t   wr_data;
  logic              accept;
  logic              deliver;

  spmr_lcg u_lcg (
    .clk        (clk),
    .state      (lcg_state),
    .state_next (step_next)
  );

  spmr_slot #(.TABLE_SIZE(TABLE_SIZE)) u_slot (
    .clk   (clk),
    .value (last_output),
    .slot  (slot)
  );

  spmr_table #(.TABLE_SIZE(TABLE_SIZE)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

  assign req.ready = (state == spmr_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign deliver   = (state == spmr_pkg::ST_DRAW_D) && (!rsp.valid || rsp.ready);
  assign rd_en     = (state == spmr_pkg::ST_DRAW_C);

  // Seeds of zero and of the modulus itself both reduce to zero and start from one.
  always_comb begin
    if (req.seed == '0 || req.seed == spmr_pkg::PM_MODULUS) begin
      seed_fixed = spmr_pkg::WORD_W'(1);
    end else begin
      seed_fixed = req.seed;
    end
  end

  // The table fills from the highest slot down to slot zero.
  always_comb begin
    fill_pos = CNT_LAST - cnt;
    wr_en    = 1'b0;
    wr_addr  = slot;
    wr_data  = lcg_state;
    if (state == spmr_pkg::ST_FILL_B && cnt >= CNT_WARM) begin
      wr_en   = 1'b1;
      wr_addr = fill_pos[SLOT_W-1:0];
      wr_data = step_next;
    end else if (deliver) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= spmr_pkg::ST_IDLE;
      cnt         <= '0;
      lcg_state   <= spmr_pkg::WORD_W'(1);
      last_output <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (deliver) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        spmr_pkg::ST_IDLE: begin
          if (accept) begin
            cnt <= '0;
            if (req.func == spmr_pkg::FUNC_RESEED) begin
              lcg_state <= seed_fixed;
              state     <= spmr_pkg::ST_FILL_A;
            end else if (last_output == '0) begin
              lcg_state <= spmr_pkg::WORD_W'(1);
              state     <= spmr_pkg::ST_FILL_A;
            end else begin
              state <= spmr_pkg::ST_DRAW_A;
            end
          end
        end
        spmr_pkg::ST_FILL_A: begin
          state <= spmr_pkg::ST_FILL_B;
        end
        spmr_pkg::ST_FILL_B: begin
          lcg_state <= step_next;
          if (cnt == CNT_LAST) begin
            last_output <= step_next;
            state       <= spmr_pkg::ST_DRAW_A;
          end else begin
            cnt   <= cnt + CNT_W'(1);
            state <= spmr_pkg::ST_FILL_A;
          end
        end
        spmr_pkg::ST_DRAW_A: begin
          state <= spmr_pkg::ST_DRAW_B;
        end
        spmr_pkg::ST_DRAW_B: begin
          lcg_state <= step_next;
          state     <= spmr_pkg::ST_DRAW_C;
        end
        spmr_pkg::ST_DRAW_C: begin
          state <= spmr_pkg::ST_DRAW_D;
        end
        spmr_pkg::ST_DRAW_D: begin
          if (deliver) begin
            last_output <= rd_data;
            state       <= spmr_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= spmr_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      rsp.random_value <= rd_data;
      rsp.next_state   <= lcg_state;
    end
  end

endmodule
